/* rtl/ccr_pkg.sv */
// shared constants, command codes and control types for the circle collision block
`default_nettype none
package ccr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int BOUNCE_BITS   = 16;
    localparam logic [16:0] BOUNCE_ONE = 17'd65536;

    // operand width of the shared multiplier and derived datapath widths
    localparam int MUL_W  = 35;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 40;
    localparam int DOT_W  = 62;

    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 6;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD_A  = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 5'd2;
    localparam logic [OP_W-1:0] OP_SQ1     = 5'd3;
    localparam logic [OP_W-1:0] OP_SQ2     = 5'd4;
    localparam logic [OP_W-1:0] OP_RS2     = 5'd5;
    localparam logic [OP_W-1:0] OP_TEST    = 5'd6;
    localparam logic [OP_W-1:0] OP_SQRT    = 5'd7;
    localparam logic [OP_W-1:0] OP_DEPTH   = 5'd8;
    localparam logic [OP_W-1:0] OP_DIVSTEP = 5'd9;
    localparam logic [OP_W-1:0] OP_DIVY    = 5'd10;
    localparam logic [OP_W-1:0] OP_MPX     = 5'd11;
    localparam logic [OP_W-1:0] OP_MPY     = 5'd12;
    localparam logic [OP_W-1:0] OP_POSY    = 5'd13;
    localparam logic [OP_W-1:0] OP_MDX     = 5'd14;
    localparam logic [OP_W-1:0] OP_MDY     = 5'd15;
    localparam logic [OP_W-1:0] OP_DOT     = 5'd16;
    localparam logic [OP_W-1:0] OP_MJ      = 5'd17;
    localparam logic [OP_W-1:0] OP_DIVA    = 5'd18;
    localparam logic [OP_W-1:0] OP_DIVB    = 5'd19;
    localparam logic [OP_W-1:0] OP_MKA     = 5'd20;
    localparam logic [OP_W-1:0] OP_MKB     = 5'd21;
    localparam logic [OP_W-1:0] OP_MVAX    = 5'd22;
    localparam logic [OP_W-1:0] OP_MVAY    = 5'd23;
    localparam logic [OP_W-1:0] OP_MVBX    = 5'd24;
    localparam logic [OP_W-1:0] OP_MVBY    = 5'd25;
    localparam logic [OP_W-1:0] OP_VEND    = 5'd26;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sel;
    } cmd_t;

    typedef struct packed {
        logic overlap;
        logic iter_last;
        logic dist_zero;
        logic impulse;
    } stat_t;

endpackage
`default_nettype wire

/* rtl/circle_circle_collision_response.sv */
// top level of the circle-circle collision response block
// a mode 0 request (body A) is taken and gives no result
// a mode 1 request gives body A after the overlap test, or after separation only,
// or after separation and an impulse; the run with overlap is set
// by the 32-step square root and two or four serial divides of FRAC_BITS+1 steps
// one pair at a time; body B follows body A; reset clears the held body to zero
`default_nettype none
module circle_circle_collision_response #(
    parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] vel_x,
    input  wire logic signed [31:0] vel_y,
    input  wire logic [30:0]        radius,
    input  wire logic [30:0]        inv_mass,
    input  wire logic [16:0]        bounce,
    input  wire logic               fixed_body,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    body_sel,
    output logic signed [31:0]      new_pos_x,
    output logic signed [31:0]      new_pos_y,
    output logic signed [31:0]      new_vel_x,
    output logic signed [31:0]      new_vel_y,
    output logic                    contact,
    output logic                    last
);

    ccr_pkg::cmd_t  cmd;
    ccr_pkg::stat_t stat;

    ccr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ccr_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .radius     (radius),
        .inv_mass   (inv_mass),
        .bounce     (bounce),
        .fixed_body (fixed_body),
        .new_pos_x  (new_pos_x),
        .new_pos_y  (new_pos_y),
        .new_vel_x  (new_vel_x),
        .new_vel_y  (new_vel_y),
        .contact    (contact)
    );

    assign body_sel = cmd.sel;
    assign last     = cmd.sel;

    // no new request while a result is pending
    a_no_overlap_io: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while a result is pending");

    // body B always follows a delivered body A
    a_b_follows_a: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !body_sel) |=> (out_valid && body_sel))
        else $error("body B did not follow body A");

    // the pair ends with the block ready again
    a_ready_after_b: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && body_sel) |=> (in_ready && !out_valid))
        else $error("block not ready after body B");

endmodule
`default_nettype wire

/* rtl/ccr_dp.sv */
// datapath: held body, working registers, shared multiplier, square root and divider
`default_nettype none
module ccr_dp #(
    parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ccr_pkg::cmd_t       cmd,
    output ccr_pkg::stat_t           stat,
    input  wire logic signed [31:0]  pos_x,
    input  wire logic signed [31:0]  pos_y,
    input  wire logic signed [31:0]  vel_x,
    input  wire logic signed [31:0]  vel_y,
    input  wire logic [30:0]         radius,
    input  wire logic [30:0]         inv_mass,
    input  wire logic [16:0]         bounce,
    input  wire logic                fixed_body,
    output logic signed [31:0]       new_pos_x,
    output logic signed [31:0]       new_pos_y,
    output logic signed [31:0]       new_vel_x,
    output logic signed [31:0]       new_vel_y,
    output logic                     contact
);

    localparam int NQ_W  = FRAC_BITS + 1;
    localparam int MUL_W = ccr_pkg::MUL_W;
    localparam int PROD_W = ccr_pkg::PROD_W;
    localparam int ACC_W = ccr_pkg::ACC_W;
    localparam int DOT_W = ccr_pkg::DOT_W;
    localparam int CNT_W = ccr_pkg::CNT_W;

    function automatic logic signed [ACC_W-1:0] sgn(input logic neg,
                                                    input logic [ACC_W-2:0] m);
        logic signed [ACC_W-1:0] t;
        t = $signed({1'b0, m});
        return neg ? -t : t;
    endfunction

    function automatic logic signed [ACC_W-1:0] sx(input logic signed [31:0] v);
        return {{(ACC_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > sx(32'sh7FFF_FFFF))
            r = 32'sh7FFF_FFFF;
        else if (v < sx(32'sh8000_0000))
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // held body A
    logic signed [31:0] held_pos_x_reg, held_pos_y_reg, held_vel_x_reg, held_vel_y_reg;
    logic [30:0]        held_radius_reg, held_inv_mass_reg;
    logic [16:0]        held_bounce_reg;
    logic               held_fixed_reg;

    logic               fb_reg, both_fixed_reg, near_reg;
    logic               dx_neg_reg, dy_neg_reg, rvx_neg_reg, rvy_neg_reg;
    logic [32:0]        adx_reg, ady_reg, rvxm_reg, rvym_reg;
    logic [31:0]        rs_reg, ims_reg, depth_reg;
    logic [30:0]        imb_reg;
    logic [17:0]        fac_reg;
    logic signed [ACC_W-1:0] wpax_reg, wpay_reg, wpbx_reg, wpby_reg;
    logic signed [ACC_W-1:0] wvax_reg, wvay_reg, wvbx_reg, wvby_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [63:0]        sq1_reg;
    logic [64:0]        s_reg;
    logic               contact_reg;
    logic [63:0]        v_reg, res_reg, bit_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        den_reg;
    logic [NQ_W-1:0]    quo_reg, nxm_reg, nym_reg, ra_reg, rb_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [MUL_W-1:0]   jm_reg, ka_reg, kb_reg;

    // request decode for body B
    logic signed [32:0] dx_c, dy_c, rvx_c, rvy_c;
    logic [32:0]        adx_c, ady_c;
    logic [31:0]        rs_c;
    logic [16:0]        bmin_c, e_c;

    assign dx_c  = {pos_x[31], pos_x} - {held_pos_x_reg[31], held_pos_x_reg};
    assign dy_c  = {pos_y[31], pos_y} - {held_pos_y_reg[31], held_pos_y_reg};
    assign rvx_c = {vel_x[31], vel_x} - {held_vel_x_reg[31], held_vel_x_reg};
    assign rvy_c = {vel_y[31], vel_y} - {held_vel_y_reg[31], held_vel_y_reg};
    assign adx_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
    assign ady_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
    assign rs_c  = {1'b0, held_radius_reg} + {1'b0, radius};
    assign bmin_c = (held_bounce_reg < bounce) ? held_bounce_reg : bounce;
    assign e_c    = (bmin_c > ccr_pkg::BOUNCE_ONE) ? ccr_pkg::BOUNCE_ONE : bmin_c;

    // shared multiplier
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic              mul_en;
    logic [DOT_W-1:0]  abs_dot;
    logic [DOT_W-1:0]  a_sh;

    assign abs_dot = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
    assign a_sh    = abs_dot >> FRAC_BITS;

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            ccr_pkg::OP_SQ1:  begin mul_a = MUL_W'(adx_reg);  mul_b = MUL_W'(adx_reg); end
            ccr_pkg::OP_SQ2:  begin mul_a = MUL_W'(ady_reg);  mul_b = MUL_W'(ady_reg); end
            ccr_pkg::OP_RS2:  begin mul_a = MUL_W'(rs_reg);   mul_b = MUL_W'(rs_reg); end
            ccr_pkg::OP_MPX:  begin mul_a = MUL_W'(nxm_reg);  mul_b = MUL_W'(depth_reg); end
            ccr_pkg::OP_MPY:  begin mul_a = MUL_W'(nym_reg);  mul_b = MUL_W'(depth_reg); end
            ccr_pkg::OP_MDX:  begin mul_a = MUL_W'(rvxm_reg); mul_b = MUL_W'(nxm_reg); end
            ccr_pkg::OP_MDY:  begin mul_a = MUL_W'(rvym_reg); mul_b = MUL_W'(nym_reg); end
            ccr_pkg::OP_MJ:   begin mul_a = a_sh[MUL_W-1:0];  mul_b = MUL_W'(fac_reg); end
            ccr_pkg::OP_MKA:  begin mul_a = jm_reg;           mul_b = MUL_W'(ra_reg); end
            ccr_pkg::OP_MKB:  begin mul_a = jm_reg;           mul_b = MUL_W'(rb_reg); end
            ccr_pkg::OP_MVAX: begin mul_a = MUL_W'(nxm_reg);  mul_b = ka_reg; end
            ccr_pkg::OP_MVAY: begin mul_a = MUL_W'(nym_reg);  mul_b = ka_reg; end
            ccr_pkg::OP_MVBX: begin mul_a = MUL_W'(nxm_reg);  mul_b = kb_reg; end
            ccr_pkg::OP_MVBY: begin mul_a = MUL_W'(nym_reg);  mul_b = kb_reg; end
            default:          mul_en = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // product scaled back by the fraction, whole or halved
    logic [PROD_W-1:0] sh_f, sh_h;
    logic [ACC_W-2:0]  mf, mh;
    assign sh_f = prod_reg >> FRAC_BITS;
    assign sh_h = prod_reg >> (FRAC_BITS + 1);
    assign mf   = sh_f[ACC_W-2:0];
    assign mh   = sh_h[ACC_W-2:0];

    // dot product terms
    logic signed [DOT_W-1:0] tmag, term_x, term_y, dot_sum;
    assign tmag    = $signed({1'b0, prod_reg[DOT_W-2:0]});
    assign term_x  = (rvx_neg_reg ^ dx_neg_reg) ? -tmag : tmag;
    assign term_y  = (rvy_neg_reg ^ dy_neg_reg) ? -tmag : tmag;
    assign dot_sum = dot_reg + term_y;

    // square root step
    logic [63:0] sq_try;
    logic        sq_ge;
    assign sq_try = res_reg + bit_reg;
    assign sq_ge  = v_reg >= sq_try;

    // divider step, the first step takes the integer bit unshifted
    logic [33:0] div_t;
    logic        div_ge;
    logic [33:0] div_d;
    assign div_t  = (cnt_reg == CNT_W'(NQ_W)) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign div_ge = div_t >= {2'b0, den_reg};
    assign div_d  = div_t - {2'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_pos_x_reg    <= '0;
            held_pos_y_reg    <= '0;
            held_vel_x_reg    <= '0;
            held_vel_y_reg    <= '0;
            held_radius_reg   <= '0;
            held_inv_mass_reg <= '0;
            held_bounce_reg   <= '0;
            held_fixed_reg    <= 1'b0;
            contact_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.op == ccr_pkg::OP_LOAD_A)
            begin
                held_pos_x_reg    <= pos_x;
                held_pos_y_reg    <= pos_y;
                held_vel_x_reg    <= vel_x;
                held_vel_y_reg    <= vel_y;
                held_radius_reg   <= radius;
                held_inv_mass_reg <= inv_mass;
                held_bounce_reg   <= bounce;
                held_fixed_reg    <= fixed_body;
            end
            if (cmd.op == ccr_pkg::OP_LOAD_B)
                contact_reg <= 1'b0;
            else if (cmd.op == ccr_pkg::OP_TEST)
                contact_reg <= stat.overlap;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_p;
        case (cmd.op)
            ccr_pkg::OP_LOAD_B:
            begin
                fb_reg         <= fixed_body;
                both_fixed_reg <= held_fixed_reg & fixed_body;
                dx_neg_reg     <= dx_c[32];
                dy_neg_reg     <= dy_c[32];
                adx_reg        <= adx_c;
                ady_reg        <= ady_c;
                near_reg       <= (adx_c <= {1'b0, rs_c}) && (ady_c <= {1'b0, rs_c});
                rs_reg         <= rs_c;
                rvx_neg_reg    <= rvx_c[32];
                rvy_neg_reg    <= rvy_c[32];
                rvxm_reg       <= rvx_c[32] ? 33'(-rvx_c) : 33'(rvx_c);
                rvym_reg       <= rvy_c[32] ? 33'(-rvy_c) : 33'(rvy_c);
                imb_reg        <= inv_mass;
                ims_reg        <= {1'b0, held_inv_mass_reg} + {1'b0, inv_mass};
                fac_reg        <= 18'(ccr_pkg::BOUNCE_ONE) + 18'(e_c);
                wpax_reg       <= sx(held_pos_x_reg);
                wpay_reg       <= sx(held_pos_y_reg);
                wvax_reg       <= sx(held_vel_x_reg);
                wvay_reg       <= sx(held_vel_y_reg);
                wpbx_reg       <= sx(pos_x);
                wpby_reg       <= sx(pos_y);
                wvbx_reg       <= sx(vel_x);
                wvby_reg       <= sx(vel_y);
            end
            ccr_pkg::OP_SQ2: sq1_reg <= prod_reg[63:0];
            ccr_pkg::OP_RS2: s_reg <= {1'b0, sq1_reg} + {1'b0, prod_reg[63:0]};
            ccr_pkg::OP_TEST:
            begin
                v_reg   <= s_reg[63:0];
                res_reg <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
                cnt_reg <= CNT_W'(ccr_pkg::SQRT_STEPS);
            end
            ccr_pkg::OP_SQRT:
            begin
                if (sq_ge)
                begin
                    v_reg   <= v_reg - sq_try;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 1'b1;
            end
            ccr_pkg::OP_DEPTH:
            begin
                depth_reg <= rs_reg - res_reg[31:0];
                rem_reg   <= {1'b0, adx_reg[31:0]};
                den_reg   <= res_reg[31:0];
                cnt_reg   <= CNT_W'(NQ_W);
                quo_reg   <= '0;
            end
            ccr_pkg::OP_DIVSTEP:
            begin
                rem_reg <= div_ge ? div_d[32:0] : div_t[32:0];
                quo_reg <= {quo_reg[NQ_W-2:0], div_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ccr_pkg::OP_DIVY:
            begin
                nxm_reg <= quo_reg;
                rem_reg <= {1'b0, ady_reg[31:0]};
                cnt_reg <= CNT_W'(NQ_W);
                quo_reg <= '0;
            end
            ccr_pkg::OP_MPX: nym_reg <= quo_reg;
            ccr_pkg::OP_MPY:
            begin
                if (held_fixed_reg)
                    wpbx_reg <= wpbx_reg + sgn(dx_neg_reg, mf);
                else if (fb_reg)
                    wpax_reg <= wpax_reg - sgn(dx_neg_reg, mf);
                else
                begin
                    wpax_reg <= wpax_reg - sgn(dx_neg_reg, mh);
                    wpbx_reg <= wpbx_reg + sgn(dx_neg_reg, mh);
                end
            end
            ccr_pkg::OP_POSY:
            begin
                if (held_fixed_reg)
                    wpby_reg <= wpby_reg + sgn(dy_neg_reg, mf);
                else if (fb_reg)
                    wpay_reg <= wpay_reg - sgn(dy_neg_reg, mf);
                else
                begin
                    wpay_reg <= wpay_reg - sgn(dy_neg_reg, mh);
                    wpby_reg <= wpby_reg + sgn(dy_neg_reg, mh);
                end
            end
            ccr_pkg::OP_MDY: dot_reg <= term_x;
            ccr_pkg::OP_DOT: dot_reg <= dot_sum;
            ccr_pkg::OP_DIVA:
            begin
                jm_reg  <= MUL_W'(prod_reg >> ccr_pkg::BOUNCE_BITS);
                rem_reg <= {2'b0, held_inv_mass_reg};
                den_reg <= ims_reg;
                cnt_reg <= CNT_W'(NQ_W);
                quo_reg <= '0;
            end
            ccr_pkg::OP_DIVB:
            begin
                ra_reg  <= quo_reg;
                rem_reg <= {2'b0, imb_reg};
                cnt_reg <= CNT_W'(NQ_W);
                quo_reg <= '0;
            end
            ccr_pkg::OP_MKA:  rb_reg <= quo_reg;
            ccr_pkg::OP_MKB:  ka_reg <= sh_f[MUL_W-1:0];
            ccr_pkg::OP_MVAX: kb_reg <= sh_f[MUL_W-1:0];
            ccr_pkg::OP_MVAY: wvax_reg <= wvax_reg - sgn(dx_neg_reg, mf);
            ccr_pkg::OP_MVBX: wvay_reg <= wvay_reg - sgn(dy_neg_reg, mf);
            ccr_pkg::OP_MVBY: wvbx_reg <= wvbx_reg + sgn(dx_neg_reg, mf);
            ccr_pkg::OP_VEND: wvby_reg <= wvby_reg + sgn(dy_neg_reg, mf);
            default: ;
        endcase
    end

    assign stat.overlap   = near_reg && !both_fixed_reg && (s_reg <= {1'b0, prod_reg[63:0]});
    assign stat.iter_last = (cnt_reg == CNT_W'(1));
    assign stat.dist_zero = (res_reg[31:0] == 32'd0);
    assign stat.impulse   = (dot_sum[DOT_W-1] || (dot_sum == '0)) && (ims_reg != 32'd0);

    assign new_pos_x = sat32(cmd.sel ? wpbx_reg : wpax_reg);
    assign new_pos_y = sat32(cmd.sel ? wpby_reg : wpay_reg);
    assign new_vel_x = sat32(cmd.sel ? wvbx_reg : wvax_reg);
    assign new_vel_y = sat32(cmd.sel ? wvby_reg : wvay_reg);
    assign contact   = contact_reg;

endmodule
`default_nettype wire

/* rtl/ccr_ctrl.sv */
// controller state machine sequencing the collision datapath
`default_nettype none
module ccr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           mode,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire ccr_pkg::stat_t stat,
    output ccr_pkg::cmd_t       cmd
);

    localparam logic [5:0] S_IDLE     = 6'd0;
    localparam logic [5:0] S_SQ1      = 6'd1;
    localparam logic [5:0] S_SQ2      = 6'd2;
    localparam logic [5:0] S_RS2      = 6'd3;
    localparam logic [5:0] S_TEST     = 6'd4;
    localparam logic [5:0] S_SQRT     = 6'd5;
    localparam logic [5:0] S_DEPTH    = 6'd6;
    localparam logic [5:0] S_DIVX_RUN = 6'd7;
    localparam logic [5:0] S_DIVY     = 6'd8;
    localparam logic [5:0] S_DIVY_RUN = 6'd9;
    localparam logic [5:0] S_MPX      = 6'd10;
    localparam logic [5:0] S_MPY      = 6'd11;
    localparam logic [5:0] S_POSY     = 6'd12;
    localparam logic [5:0] S_MDX      = 6'd13;
    localparam logic [5:0] S_MDY      = 6'd14;
    localparam logic [5:0] S_DOT      = 6'd15;
    localparam logic [5:0] S_MJ       = 6'd16;
    localparam logic [5:0] S_DIVA     = 6'd17;
    localparam logic [5:0] S_DIVA_RUN = 6'd18;
    localparam logic [5:0] S_DIVB     = 6'd19;
    localparam logic [5:0] S_DIVB_RUN = 6'd20;
    localparam logic [5:0] S_MKA      = 6'd21;
    localparam logic [5:0] S_MKB      = 6'd22;
    localparam logic [5:0] S_MVAX     = 6'd23;
    localparam logic [5:0] S_MVAY     = 6'd24;
    localparam logic [5:0] S_MVBX     = 6'd25;
    localparam logic [5:0] S_MVBY     = 6'd26;
    localparam logic [5:0] S_VEND     = 6'd27;
    localparam logic [5:0] S_OUTA     = 6'd28;
    localparam logic [5:0] S_OUTB     = 6'd29;

    logic [5:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = ccr_pkg::OP_NOP;
        cmd.sel    = (state_reg == S_OUTB);
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (mode)
                    begin
                        cmd.op     = ccr_pkg::OP_LOAD_B;
                        state_next = S_SQ1;
                    end
                    else
                        cmd.op = ccr_pkg::OP_LOAD_A;
                end
            end
            S_SQ1: begin cmd.op = ccr_pkg::OP_SQ1; state_next = S_SQ2; end
            S_SQ2: begin cmd.op = ccr_pkg::OP_SQ2; state_next = S_RS2; end
            S_RS2: begin cmd.op = ccr_pkg::OP_RS2; state_next = S_TEST; end
            S_TEST:
            begin
                cmd.op     = ccr_pkg::OP_TEST;
                state_next = stat.overlap ? S_SQRT : S_OUTA;
            end
            S_SQRT:
            begin
                cmd.op = ccr_pkg::OP_SQRT;
                if (stat.iter_last)
                    state_next = S_DEPTH;
            end
            S_DEPTH:
            begin
                // coincident centres skip the normal, nothing moves
                cmd.op     = ccr_pkg::OP_DEPTH;
                state_next = stat.dist_zero ? S_OUTA : S_DIVX_RUN;
            end
            S_DIVX_RUN:
            begin
                cmd.op = ccr_pkg::OP_DIVSTEP;
                if (stat.iter_last)
                    state_next = S_DIVY;
            end
            S_DIVY: begin cmd.op = ccr_pkg::OP_DIVY; state_next = S_DIVY_RUN; end
            S_DIVY_RUN:
            begin
                cmd.op = ccr_pkg::OP_DIVSTEP;
                if (stat.iter_last)
                    state_next = S_MPX;
            end
            S_MPX:  begin cmd.op = ccr_pkg::OP_MPX;  state_next = S_MPY; end
            S_MPY:  begin cmd.op = ccr_pkg::OP_MPY;  state_next = S_POSY; end
            S_POSY: begin cmd.op = ccr_pkg::OP_POSY; state_next = S_MDX; end
            S_MDX:  begin cmd.op = ccr_pkg::OP_MDX;  state_next = S_MDY; end
            S_MDY:  begin cmd.op = ccr_pkg::OP_MDY;  state_next = S_DOT; end
            S_DOT:
            begin
                cmd.op     = ccr_pkg::OP_DOT;
                state_next = stat.impulse ? S_MJ : S_OUTA;
            end
            S_MJ:   begin cmd.op = ccr_pkg::OP_MJ;   state_next = S_DIVA; end
            S_DIVA: begin cmd.op = ccr_pkg::OP_DIVA; state_next = S_DIVA_RUN; end
            S_DIVA_RUN:
            begin
                cmd.op = ccr_pkg::OP_DIVSTEP;
                if (stat.iter_last)
                    state_next = S_DIVB;
            end
            S_DIVB: begin cmd.op = ccr_pkg::OP_DIVB; state_next = S_DIVB_RUN; end
            S_DIVB_RUN:
            begin
                cmd.op = ccr_pkg::OP_DIVSTEP;
                if (stat.iter_last)
                    state_next = S_MKA;
            end
            S_MKA:  begin cmd.op = ccr_pkg::OP_MKA;  state_next = S_MKB; end
            S_MKB:  begin cmd.op = ccr_pkg::OP_MKB;  state_next = S_MVAX; end
            S_MVAX: begin cmd.op = ccr_pkg::OP_MVAX; state_next = S_MVAY; end
            S_MVAY: begin cmd.op = ccr_pkg::OP_MVAY; state_next = S_MVBX; end
            S_MVBX: begin cmd.op = ccr_pkg::OP_MVBX; state_next = S_MVBY; end
            S_MVBY: begin cmd.op = ccr_pkg::OP_MVBY; state_next = S_VEND; end
            S_VEND: begin cmd.op = ccr_pkg::OP_VEND; state_next = S_OUTA; end
            S_OUTA:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_OUTB;
            end
            S_OUTB:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire
